@@ sv/spma_pkg.sv @@
// Package for the sparse polynomial merge-add block.
// Holds sizes, action codes and the term, result and shared-unit types.
// No dependencies.
`default_nettype none

package spma_pkg;

    localparam int MAX_TERMS  = 32;
    localparam int COEFF_BITS = 16;
    localparam int EXP_BITS   = 16;

    localparam int SUM_BITS      = COEFF_BITS + 1;
    localparam int ADDR_BITS     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CNT_BITS      = $clog2(MAX_TERMS + 1);
    localparam int IN_DATA_BITS  = ((COEFF_BITS + EXP_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((SUM_BITS + EXP_BITS + 7) / 8) * 8;

    localparam logic [1:0] ACT_LOAD_A = 2'd0;
    localparam logic [1:0] ACT_LOAD_B = 2'd1;
    localparam logic [1:0] ACT_RUN    = 2'd2;
    localparam logic [1:0] ACT_CLEAR  = 2'd3;

    typedef struct packed {
        logic [EXP_BITS-1:0]          exp;
        logic signed [COEFF_BITS-1:0] coeff;
    } t_term;

    localparam int TERM_BITS = $bits(t_term);

    typedef struct packed {
        t_term a;
        t_term b;
        logic  a_ok;
        logic  b_ok;
    } t_alu_req;

    typedef struct packed {
        logic signed [SUM_BITS-1:0] coeff;
        logic [EXP_BITS-1:0]        exp;
        logic                       take_a;
        logic                       take_b;
    } t_alu_res;

    typedef struct packed {
        logic signed [SUM_BITS-1:0] coeff;
        logic [EXP_BITS-1:0]        exp;
        logic                       last;
        logic                       empty;
    } t_result;

endpackage

`default_nettype wire

@@ sv/spma_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module spma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                 i_wdata,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ sv/spma_alu.sv @@
// Shared compare/add unit: picks the next merged term from the heads of both lists.
// Depends on spma_pkg.
`default_nettype none

module spma_alu (
    input  wire spma_pkg::t_alu_req i_req,
    output spma_pkg::t_alu_res      o_res
);
    import spma_pkg::*;

    always_comb begin
        o_res = '0;
        if (i_req.a_ok && i_req.b_ok) begin
            if (i_req.a.exp == i_req.b.exp) begin
                o_res.coeff  = SUM_BITS'(i_req.a.coeff) + SUM_BITS'(i_req.b.coeff);
                o_res.exp    = i_req.a.exp;
                o_res.take_a = 1'b1;
                o_res.take_b = 1'b1;
            end else if (i_req.a.exp > i_req.b.exp) begin
                o_res.coeff  = SUM_BITS'(i_req.a.coeff);
                o_res.exp    = i_req.a.exp;
                o_res.take_a = 1'b1;
            end else begin
                o_res.coeff  = SUM_BITS'(i_req.b.coeff);
                o_res.exp    = i_req.b.exp;
                o_res.take_b = 1'b1;
            end
        end else if (i_req.a_ok) begin
            o_res.coeff  = SUM_BITS'(i_req.a.coeff);
            o_res.exp    = i_req.a.exp;
            o_res.take_a = 1'b1;
        end else begin
            o_res.coeff  = SUM_BITS'(i_req.b.coeff);
            o_res.exp    = i_req.b.exp;
            o_res.take_b = 1'b1;
        end
    end

endmodule

`default_nettype wire

@@ sv/spma_ctrl.sv @@
// Sequencer: list fill counts, load/clear handling, merge walk and output register.
// Depends on spma_pkg; drives spma_alu and the two list RAMs.
`default_nettype none

module spma_ctrl (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [1:0]                      i_action,
    output logic                                 o_we_a,
    output logic                                 o_we_b,
    output logic [spma_pkg::ADDR_BITS-1:0]       o_waddr_a,
    output logic [spma_pkg::ADDR_BITS-1:0]       o_waddr_b,
    output logic [spma_pkg::ADDR_BITS-1:0]       o_raddr_a,
    output logic [spma_pkg::ADDR_BITS-1:0]       o_raddr_b,
    input  wire spma_pkg::t_term                 i_rd_a,
    input  wire spma_pkg::t_term                 i_rd_b,
    output spma_pkg::t_alu_req                   o_alu_req,
    input  wire spma_pkg::t_alu_res              i_alu_res,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output spma_pkg::t_result                    o_out
);
    import spma_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [CNT_BITS-1:0] r_ca, n_ca, r_cb, n_cb;
    logic [CNT_BITS-1:0] r_i, n_i, r_j, n_j;
    logic                r_out_valid, n_out_valid;
    t_result             r_out, n_out;

    logic                accept;
    logic                out_free;
    logic                a_room, b_room;
    logic [CNT_BITS-1:0] i_next, j_next;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign a_room     = r_ca < CNT_BITS'(MAX_TERMS);
    assign b_room     = r_cb < CNT_BITS'(MAX_TERMS);

    assign o_we_a    = accept && (i_action == ACT_LOAD_A) && a_room;
    assign o_we_b    = accept && (i_action == ACT_LOAD_B) && b_room;
    assign o_waddr_a = r_ca[ADDR_BITS-1:0];
    assign o_waddr_b = r_cb[ADDR_BITS-1:0];
    assign o_raddr_a = r_i[ADDR_BITS-1:0];
    assign o_raddr_b = r_j[ADDR_BITS-1:0];

    assign o_alu_req.a    = i_rd_a;
    assign o_alu_req.b    = i_rd_b;
    assign o_alu_req.a_ok = r_i < r_ca;
    assign o_alu_req.b_ok = r_j < r_cb;

    assign i_next = r_i + CNT_BITS'(i_alu_res.take_a);
    assign j_next = r_j + CNT_BITS'(i_alu_res.take_b);

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_state     = r_state;
        n_ca        = r_ca;
        n_cb        = r_cb;
        n_i         = r_i;
        n_j         = r_j;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_action)
                        ACT_LOAD_A: begin
                            if (a_room) n_ca = r_ca + CNT_BITS'(1);
                        end
                        ACT_LOAD_B: begin
                            if (b_room) n_cb = r_cb + CNT_BITS'(1);
                        end
                        ACT_RUN: begin
                            n_i     = '0;
                            n_j     = '0;
                            n_state = ST_READ;
                        end
                        ACT_CLEAR: begin
                            n_ca = '0;
                            n_cb = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_ca == '0 && r_cb == '0) begin
                        n_out.coeff = '0;
                        n_out.exp   = '0;
                        n_out.last  = 1'b1;
                        n_out.empty = 1'b1;
                        n_state     = ST_IDLE;
                    end else begin
                        n_out.coeff = i_alu_res.coeff;
                        n_out.exp   = i_alu_res.exp;
                        n_out.last  = (i_next >= r_ca) && (j_next >= r_cb);
                        n_out.empty = 1'b0;
                        n_i         = i_next;
                        n_j         = j_next;
                        n_state     = n_out.last ? ST_IDLE : ST_READ;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ca        <= '0;
            r_cb        <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ca        <= n_ca;
            r_cb        <= n_cb;
            r_i         <= n_i;
            r_j         <= n_j;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

endmodule

`default_nettype wire

@@ sv/sparse_polynomial_merge_add_top.sv @@
// Sparse polynomial merge-add: two term lists loaded one request at a time, merged by
// exponent on a run request. After a run starts, each result term takes a list RAM read
// and then a pass through the shared compare/add unit, where a matched exponent pair
// gives one term and two empty lists give one flagged term; a stalled output holds the
// walk. The input is not ready until the run's last term has been placed in the output
// register. Loads into a full list are dropped.
// Depends on spma_pkg, spma_ram, spma_alu and spma_ctrl.
`default_nettype none

module sparse_polynomial_merge_add_top (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // [15:0] coeff_in, [31:16] exponent_in
    input  wire logic [spma_pkg::IN_DATA_BITS-1:0]  i_s_axis_tdata,
    // [1:0] action
    input  wire logic [1:0]                         i_s_axis_tuser,
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // [16:0] term_coeff, [32:17] term_exponent, rest zero
    output logic [spma_pkg::OUT_DATA_BITS-1:0]      o_m_axis_tdata,
    output logic                                    o_m_axis_tlast,
    // [0] lists_empty
    output logic                                    o_m_axis_tuser
);
    import spma_pkg::*;

    t_term                in_term;
    t_term                rd_a, rd_b;
    logic                 we_a, we_b;
    logic [ADDR_BITS-1:0] waddr_a, waddr_b, raddr_a, raddr_b;
    t_alu_req             alu_req;
    t_alu_res             alu_res;
    t_result              out;

    assign in_term.coeff = i_s_axis_tdata[COEFF_BITS-1:0];
    assign in_term.exp   = i_s_axis_tdata[COEFF_BITS+EXP_BITS-1:COEFF_BITS];

    spma_ram #(.WIDTH(TERM_BITS), .DEPTH(MAX_TERMS)) u_list_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr_a),
        .i_wdata (in_term),
        .i_raddr (raddr_a),
        .o_rdata (rd_a)
    );

    spma_ram #(.WIDTH(TERM_BITS), .DEPTH(MAX_TERMS)) u_list_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr_b),
        .i_wdata (in_term),
        .i_raddr (raddr_b),
        .o_rdata (rd_b)
    );

    spma_alu u_alu (
        .i_req (alu_req),
        .o_res (alu_res)
    );

    spma_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_action    (i_s_axis_tuser),
        .o_we_a      (we_a),
        .o_we_b      (we_b),
        .o_waddr_a   (waddr_a),
        .o_waddr_b   (waddr_b),
        .o_raddr_a   (raddr_a),
        .o_raddr_b   (raddr_b),
        .i_rd_a      (rd_a),
        .i_rd_b      (rd_b),
        .o_alu_req   (alu_req),
        .i_alu_res   (alu_res),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out       (out)
    );

    assign o_m_axis_tdata = OUT_DATA_BITS'({out.exp, out.coeff});
    assign o_m_axis_tlast = out.last;
    assign o_m_axis_tuser = out.empty;

endmodule

`default_nettype wire

@@ sim/tb_sparse_polynomial_merge_add_top.sv @@
// Testbench for sparse_polynomial_merge_add_top: directed and random term lists with
// merge runs, results checked in order against an in-bench merge predictor.
// Depends on spma_pkg and the sparse_polynomial_merge_add_top RTL.
`timescale 1ns / 100ps

module tb_sparse_polynomial_merge_add_top;
    import spma_pkg::*;

    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_CYCLES = 400;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_s_axis_tvalid = 1'b0;
    logic                     o_s_axis_tready;
    // [15:0] coeff_in, [31:16] exponent_in
    logic [IN_DATA_BITS-1:0]  i_s_axis_tdata = '0;
    // [1:0] action
    logic [1:0]               i_s_axis_tuser = ACT_CLEAR;
    logic                     o_m_axis_tvalid;
    logic                     i_m_axis_tready = 1'b0;
    // [16:0] term_coeff, [32:17] term_exponent, rest zero
    logic [OUT_DATA_BITS-1:0] o_m_axis_tdata;
    logic                     o_m_axis_tlast;
    // [0] lists_empty
    logic                     o_m_axis_tuser;

    sparse_polynomial_merge_add_top u_top (.*);

    t_term       poly_a [MAX_TERMS];
    t_term       poly_b [MAX_TERMS];
    int unsigned count_a = 0;
    int unsigned count_b = 0;
    t_result     expected_terms [$];

    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned hold_asked = 0;
    int unsigned hold_taken = 0;
    int unsigned mismatches = 0;
    int unsigned idle_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void predict_terms(input logic [1:0] act,
                                          input logic [COEFF_BITS-1:0] coeff,
                                          input logic [EXP_BITS-1:0] expo);
        int unsigned i;
        int unsigned j;
        t_result     r;
        i = 0;
        j = 0;
        case (act)
            ACT_LOAD_A: begin
                if (count_a < MAX_TERMS) begin
                    poly_a[count_a].coeff = coeff;
                    poly_a[count_a].exp   = expo;
                    count_a++;
                end
            end
            ACT_LOAD_B: begin
                if (count_b < MAX_TERMS) begin
                    poly_b[count_b].coeff = coeff;
                    poly_b[count_b].exp   = expo;
                    count_b++;
                end
            end
            ACT_CLEAR: begin
                count_a = 0;
                count_b = 0;
            end
            default: begin
                if (count_a == 0 && count_b == 0) begin
                    r       = '0;
                    r.last  = 1'b1;
                    r.empty = 1'b1;
                    expected_terms.push_back(r);
                end
                while (i < count_a || j < count_b) begin
                    r = '0;
                    if (i < count_a && j < count_b && poly_a[i].exp == poly_b[j].exp) begin
                        r.coeff = SUM_BITS'($signed(poly_a[i].coeff))
                                + SUM_BITS'($signed(poly_b[j].coeff));
                        r.exp   = poly_a[i].exp;
                        i++;
                        j++;
                    end else if (i < count_a && (j >= count_b || poly_a[i].exp > poly_b[j].exp)) begin
                        r.coeff = SUM_BITS'($signed(poly_a[i].coeff));
                        r.exp   = poly_a[i].exp;
                        i++;
                    end else begin
                        r.coeff = SUM_BITS'($signed(poly_b[j].coeff));
                        r.exp   = poly_b[j].exp;
                        j++;
                    end
                    r.last = (i >= count_a && j >= count_b);
                    expected_terms.push_back(r);
                end
            end
        endcase
    endfunction

    function automatic logic [COEFF_BITS-1:0] rand_coeff();
        case ($urandom_range(9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            default: return COEFF_BITS'($urandom_range(65535));
        endcase
    endfunction

    // returns right after the accepting edge with tvalid still high
    task automatic send_request(input logic [1:0] act, input logic [COEFF_BITS-1:0] coeff,
                                input logic [EXP_BITS-1:0] expo);
        int unsigned gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < tx_idle_pct) gap++;
        repeat (gap) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= act;
        i_s_axis_tdata  <= IN_DATA_BITS'({expo, coeff});
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_terms(act, coeff, expo);
    endtask

    task automatic note_mismatch(input string msg);
        if (mismatches < 10) $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic test_directed();
        tx_idle_pct = 28;
        rx_idle_pct = 61;
        send_request(ACT_RUN, 16'h0, 16'h0);
        send_request(ACT_LOAD_A, 16'h7FFF, 16'hFFFF);
        send_request(ACT_LOAD_B, 16'h7FFF, 16'hFFFF);
        send_request(ACT_LOAD_A, 16'h8000, 16'd1000);
        send_request(ACT_LOAD_B, 16'h8000, 16'd1000);
        send_request(ACT_LOAD_A, 16'd9, 16'd500);
        send_request(ACT_LOAD_B, 16'd1, 16'd200);
        send_request(ACT_LOAD_A, 16'd5, 16'd0);
        send_request(ACT_LOAD_B, 16'hFFFB, 16'd0);
        send_request(ACT_RUN, 16'hFFFF, 16'hFFFF);
        send_request(ACT_RUN, 16'h0, 16'h0);
        send_request(ACT_CLEAR, 16'hFFFF, 16'hFFFF);
        send_request(ACT_RUN, 16'h0, 16'h0);
        send_request(ACT_LOAD_B, 16'hFFFF, 16'd7);
        send_request(ACT_LOAD_B, 16'd2, 16'd3);
        send_request(ACT_RUN, 16'h0, 16'h0);
        send_request(ACT_CLEAR, 16'h0, 16'h0);
        send_request(ACT_LOAD_A, 16'd100, 16'd4);
        send_request(ACT_RUN, 16'h0, 16'h0);
        // unordered lists
        send_request(ACT_LOAD_A, 16'd3, 16'd10);
        send_request(ACT_LOAD_B, 16'd7, 16'd8);
        send_request(ACT_LOAD_B, 16'd1, 16'd4);
        send_request(ACT_RUN, 16'h0, 16'h0);
        send_request(ACT_CLEAR, 16'h0, 16'h0);
    endtask

    // both lists overfilled, merge of 64 terms while the output side holds off
    task automatic test_full_lists_stalled();
        int k;
        send_request(ACT_CLEAR, 16'h0, 16'h0);
        for (k = 0; k < MAX_TERMS + 2; k++)
            send_request(ACT_LOAD_A, rand_coeff(), EXP_BITS'(65535 - 2 * k));
        for (k = 0; k < MAX_TERMS + 1; k++)
            send_request(ACT_LOAD_B, rand_coeff(), EXP_BITS'(65534 - 2 * k));
        hold_asked++;
        send_request(ACT_RUN, 16'h0, 16'h0);
        for (k = 0; k < 3; k++)
            send_request(ACT_LOAD_B, rand_coeff(), EXP_BITS'($urandom_range(65535)));
        send_request(ACT_RUN, 16'h0, 16'h0);
        send_request(ACT_CLEAR, 16'h0, 16'h0);
    endtask

    task automatic test_random_polynomials(input int unsigned tx_pct, input int unsigned rx_pct,
                                           input int unsigned n_items);
        int unsigned sent;
        int unsigned pool_len;
        int unsigned step;
        int unsigned pick;
        int          e_int;
        t_term       qa [$];
        t_term       qb [$];
        t_term       t;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(9) == 0) begin
                send_request(2'($urandom_range(3)), COEFF_BITS'($urandom_range(65535)),
                             EXP_BITS'($urandom_range(65535)));
                sent++;
            end else begin
                if ($urandom_range(9) != 0) begin
                    send_request(ACT_CLEAR, rand_coeff(), EXP_BITS'($urandom_range(65535)));
                    sent++;
                end
                qa.delete();
                qb.delete();
                pool_len = ($urandom_range(19) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 7);
                step  = $urandom_range(1) ? 4 : 65536 / (pool_len + 1);
                e_int = ($urandom_range(3) == 0) ? 65535 : $urandom_range(65535);
                repeat (pool_len) begin
                    if (e_int >= 0) begin
                        pick = $urandom_range(2);
                        t.exp = EXP_BITS'(e_int);
                        if (pick != 1) begin
                            t.coeff = rand_coeff();
                            qa.push_back(t);
                        end
                        if (pick != 0) begin
                            t.coeff = rand_coeff();
                            qb.push_back(t);
                        end
                        e_int -= $urandom_range(1, step);
                    end
                end
                while (qa.size() != 0 || qb.size() != 0) begin
                    if (qb.size() == 0 || (qa.size() != 0 && $urandom_range(1) == 1)) begin
                        t = qa.pop_front();
                        send_request(ACT_LOAD_A, t.coeff, t.exp);
                    end else begin
                        t = qb.pop_front();
                        send_request(ACT_LOAD_B, t.coeff, t.exp);
                    end
                    sent++;
                end
                send_request(ACT_RUN, COEFF_BITS'($urandom_range(65535)),
                             EXP_BITS'($urandom_range(65535)));
                sent++;
            end
        end
    endtask

    always begin : receiver
        @(negedge i_clk);
        if (hold_taken != hold_asked) begin
            hold_taken = hold_asked;
            i_m_axis_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge i_clk);
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin : term_checker
        t_result got;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.coeff = o_m_axis_tdata[SUM_BITS-1:0];
            got.exp   = o_m_axis_tdata[SUM_BITS +: EXP_BITS];
            got.last  = o_m_axis_tlast;
            got.empty = o_m_axis_tuser;
            if (expected_terms.size() == 0) begin
                note_mismatch($sformatf("unexpected term coeff %0d exp %0d last %b empty %b",
                                        got.coeff, got.exp, got.last, got.empty));
            end else begin
                want = expected_terms.pop_front();
                if (got.coeff !== want.coeff || got.exp !== want.exp
                    || got.last !== want.last || got.empty !== want.empty)
                    note_mismatch($sformatf({"term mismatch: expected coeff %0d exp %0d last %b ",
                                             "empty %b, got coeff %0d exp %0d last %b empty %b"},
                                            want.coeff, want.exp, want.last, want.empty,
                                            got.coeff, got.exp, got.last, got.empty));
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
            || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("sparse_polynomial_merge_add_top verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_polynomials(28, 61, 35);
        test_full_lists_stalled();
        test_random_polynomials(61, 28, 35);
        test_random_polynomials(0, 0, 35);
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (expected_terms.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_terms.size() == 0) begin
            $display("sparse_polynomial_merge_add_top verification clean");
        end else begin
            $display("sparse_polynomial_merge_add_top verification failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/spma_pkg.sv
sv/spma_ram.sv
sv/spma_alu.sv
sv/spma_ctrl.sv
sv/sparse_polynomial_merge_add_top.sv
sim/tb_sparse_polynomial_merge_add_top.sv
